// ===== rtl/core/dmwc_pkg.sv =====
// Shared constants of the direct-mapped write-back cache tag controller.
package dmwc_pkg;

    // Default geometry: 128 lines of 32 bytes, 32-bit byte addresses.
    localparam int LINE_COUNT_DEF  = 128;
    localparam int BLOCK_BYTES_DEF = 32;
    localparam int ADDR_W          = 32;

    // Widths of the result fields.
    localparam int OFFSET_W = 5;
    localparam int BLOCK_W  = 27;
    localparam int INDEX_W  = 7;
    localparam int TAG_OUT_W = 20;
    localparam int BYTES_W  = 6;

endpackage

// ===== rtl/core/dmwc_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module dmwc_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dmwc_clear.sv =====
// Post-reset line sweep; the top writes each tag RAM line invalid and clean.
module dmwc_clear #(
    parameter int LINE_COUNT = dmwc_pkg::LINE_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    output logic                          o_busy,
    output logic [$clog2(LINE_COUNT)-1:0] o_idx
);

    localparam int IDX_W = $clog2(LINE_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_COUNT - 1);

    logic             r_busy;
    logic             n_busy;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (r_busy) begin
            n_idx = r_idx + IDX_W'(1);
            if (r_idx == LAST_IDX) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    assign o_busy = r_busy;
    assign o_idx  = r_idx;

`ifndef SYNTH
    a_idx_zero_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_idx == '0)
        else $error("clear sweep ended with a nonzero line counter");
    a_stays_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> !r_busy)
        else $error("clear sweep restarted without reset");
`endif

endmodule

// ===== rtl/core/direct_mapped_writeback_cache_tags_top.sv =====
// Top level of the direct-mapped write-back, write-allocate cache tag controller.
// Each request carries a byte address and a read/write flag and yields one result from
// the result register after the lookup stage, and while results are taken a new request
// can be accepted in every cycle, so the sustained rate is one request per cycle. Valid,
// dirty and tag of each line live together in one RAM with a registered read: a request
// reads its line in the cycle it is accepted, compares and writes the updated line back
// when the lookup stage advances, and the line just written is forwarded to a following
// request for the same line. A result that is not taken holds the lookup stage, which then
// stops accepting. After reset the block sweeps the RAM to mark every line invalid; no
// request is accepted during the sweep. BLOCK_BYTES and LINE_COUNT must be powers of two.
module direct_mapped_writeback_cache_tags_top #(
    parameter int LINE_COUNT  = dmwc_pkg::LINE_COUNT_DEF,
    parameter int BLOCK_BYTES = dmwc_pkg::BLOCK_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [dmwc_pkg::ADDR_W-1:0]      i_address,
    input  logic                             i_action,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [dmwc_pkg::OFFSET_W-1:0]    o_byte_offset,
    output logic [dmwc_pkg::BLOCK_W-1:0]     o_block_number,
    output logic [dmwc_pkg::INDEX_W-1:0]     o_line_index,
    output logic [dmwc_pkg::TAG_OUT_W-1:0]   o_tag_value,
    output logic                             o_is_miss,
    output logic                             o_fetch_block,
    output logic [dmwc_pkg::BYTES_W-1:0]     o_fetch_bytes,
    output logic                             o_write_back,
    output logic [dmwc_pkg::BYTES_W-1:0]     o_write_back_bytes,
    output logic                             o_replaced,
    output logic [dmwc_pkg::TAG_OUT_W-1:0]   o_evicted_tag
);

    localparam int ADDR_W   = dmwc_pkg::ADDR_W;
    localparam int BYTES_W  = dmwc_pkg::BYTES_W;
    localparam int OFF_W    = $clog2(BLOCK_BYTES);
    localparam int IDX_W    = $clog2(LINE_COUNT);
    localparam int TAG_W    = ADDR_W - OFF_W - IDX_W;
    localparam int ENT_W    = TAG_W + 2;
    localparam logic [ADDR_W-1:0]  OFF_MASK = ADDR_W'(BLOCK_BYTES - 1);
    localparam logic [ADDR_W-1:0]  IDX_MASK = ADDR_W'(LINE_COUNT - 1);
    localparam logic [BYTES_W-1:0] BLOCK_BYTES_FIELD = BYTES_W'(BLOCK_BYTES % (1 << BYTES_W));

    // Lookup stage.
    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_wr;

    // Last RAM write, for forwarding to the next lookup.
    logic              r_fwd_valid;
    logic [IDX_W-1:0]  r_fwd_idx;
    logic [ENT_W-1:0]  r_fwd_entry;

    // Result register.
    logic                            r_out_valid;
    logic [dmwc_pkg::OFFSET_W-1:0]   r_out_offset;
    logic [dmwc_pkg::BLOCK_W-1:0]    r_out_block;
    logic [dmwc_pkg::INDEX_W-1:0]    r_out_line;
    logic [dmwc_pkg::TAG_OUT_W-1:0]  r_out_tag;
    logic                            r_out_miss;
    logic                            r_out_wb;
    logic                            r_out_repl;
    logic [dmwc_pkg::TAG_OUT_W-1:0]  r_out_etag;

    logic              clr_busy;
    logic [IDX_W-1:0]  clr_idx;
    logic [ENT_W-1:0]  ram_rdata;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;

    logic              s1_adv;
    logic              in_accept;
    logic [ADDR_W-1:0] in_block;
    logic [ADDR_W-1:0] s1_block;
    logic [ADDR_W-1:0] s1_tag_full;
    logic [IDX_W-1:0]  s1_idx;
    logic [TAG_W-1:0]  s1_tag;
    logic [ENT_W-1:0]  s1_entry;
    logic              ent_valid;
    logic              ent_dirty;
    logic [TAG_W-1:0]  ent_tag;
    logic              s1_hit;
    logic [ENT_W-1:0]  s1_new_entry;

    dmwc_clear #(
        .LINE_COUNT(LINE_COUNT)
    ) u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (clr_busy),
        .o_idx   (clr_idx)
    );

    dmwc_ram #(
        .WIDTH(ENT_W),
        .DEPTH(LINE_COUNT)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        s1_adv    = r_s1_valid && (!r_out_valid || i_ready);
        o_ready   = !clr_busy && (!r_s1_valid || s1_adv);
        in_accept = i_valid && o_ready;

        in_block    = i_address >> OFF_W;
        s1_block    = r_s1_addr >> OFF_W;
        s1_tag_full = s1_block >> IDX_W;
        s1_idx      = s1_block[IDX_W-1:0];
        s1_tag      = s1_tag_full[TAG_W-1:0];

        // A stalled lookup keeps re-reading its own line so the RAM output stays current.
        ram_raddr = (r_s1_valid && !s1_adv) ? s1_idx : in_block[IDX_W-1:0];

        s1_entry  = (r_fwd_valid && r_fwd_idx == s1_idx) ? r_fwd_entry : ram_rdata;
        ent_valid = s1_entry[ENT_W-1];
        ent_dirty = s1_entry[ENT_W-2];
        ent_tag   = s1_entry[TAG_W-1:0];
        s1_hit    = ent_valid && (ent_tag == s1_tag);

        // Hit keeps the line and ORs in a write; miss refills it, dirty only for a write.
        s1_new_entry = {1'b1, s1_hit ? (ent_dirty || r_s1_wr) : r_s1_wr, s1_tag};

        ram_we    = clr_busy || s1_adv;
        ram_waddr = clr_busy ? clr_idx : s1_idx;
        ram_wdata = clr_busy ? '0 : s1_new_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            r_fwd_valid <= ram_we;
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_addr <= i_address;
            r_s1_wr   <= i_action;
        end
        r_fwd_idx   <= ram_waddr;
        r_fwd_entry <= ram_wdata;
        if (s1_adv) begin
            r_out_offset <= dmwc_pkg::OFFSET_W'(r_s1_addr & OFF_MASK);
            r_out_block  <= dmwc_pkg::BLOCK_W'(s1_block);
            r_out_line   <= dmwc_pkg::INDEX_W'(s1_block & IDX_MASK);
            r_out_tag    <= dmwc_pkg::TAG_OUT_W'(s1_tag_full);
            r_out_miss   <= !s1_hit;
            r_out_repl   <= !s1_hit && ent_valid;
            r_out_wb     <= !s1_hit && ent_valid && ent_dirty;
            r_out_etag   <= (!s1_hit && ent_valid)
                            ? dmwc_pkg::TAG_OUT_W'(ADDR_W'(ent_tag)) : '0;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_byte_offset      = r_out_offset;
    assign o_block_number     = r_out_block;
    assign o_line_index       = r_out_line;
    assign o_tag_value        = r_out_tag;
    assign o_is_miss          = r_out_miss;
    assign o_fetch_block      = r_out_miss;
    assign o_fetch_bytes      = r_out_miss ? BLOCK_BYTES_FIELD : '0;
    assign o_write_back       = r_out_wb;
    assign o_write_back_bytes = r_out_wb ? BLOCK_BYTES_FIELD : '0;
    assign o_replaced         = r_out_repl;
    assign o_evicted_tag      = r_out_etag;

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !o_ready && !r_s1_valid)
        else $error("request taken during the clear sweep");
    a_wb_needs_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_wb |-> r_out_repl && r_out_miss)
        else $error("write-back reported without a replaced line");
    a_etag_zero_no_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_repl |-> r_out_etag == '0)
        else $error("evicted tag nonzero with nothing replaced");
    a_result_follows_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("lookup advanced without loading the result register");
    a_refill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_fwd_valid && r_fwd_entry[ENT_W-1])
        else $error("lookup wrote back an invalid line");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the direct-mapped write-back cache tag controller.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   ADDR_W     = dmwc_pkg::ADDR_W;
    localparam int   OFFSET_W   = dmwc_pkg::OFFSET_W;
    localparam int   BLOCK_W    = dmwc_pkg::BLOCK_W;
    localparam int   INDEX_W    = dmwc_pkg::INDEX_W;
    localparam int   TAG_OUT_W  = dmwc_pkg::TAG_OUT_W;
    localparam int   BYTES_W    = dmwc_pkg::BYTES_W;
    localparam logic ACT_READ   = 1'b0;
    localparam logic ACT_WRITE  = 1'b1;
    localparam int   LINES      = dmwc_pkg::LINE_COUNT_DEF;
    localparam int   BLOCK_SIZE = dmwc_pkg::BLOCK_BYTES_DEF;
    localparam int   STALL_LIMIT = 2000;

    typedef struct {
        logic [OFFSET_W-1:0]  byte_offset;
        logic [BLOCK_W-1:0]   block_number;
        logic [INDEX_W-1:0]   line_index;
        logic [TAG_OUT_W-1:0] tag_value;
        logic                 is_miss;
        logic                 fetch_block;
        logic [BYTES_W-1:0]   fetch_bytes;
        logic                 write_back;
        logic [BYTES_W-1:0]   write_back_bytes;
        logic                 replaced;
        logic [TAG_OUT_W-1:0] evicted_tag;
    } t_cache_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [ADDR_W-1:0]      i_address = '0;
    logic                   i_action = ACT_READ;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [OFFSET_W-1:0]    o_byte_offset;
    logic [BLOCK_W-1:0]     o_block_number;
    logic [INDEX_W-1:0]     o_line_index;
    logic [TAG_OUT_W-1:0]   o_tag_value;
    logic                   o_is_miss;
    logic                   o_fetch_block;
    logic [BYTES_W-1:0]     o_fetch_bytes;
    logic                   o_write_back;
    logic [BYTES_W-1:0]     o_write_back_bytes;
    logic                   o_replaced;
    logic [TAG_OUT_W-1:0]   o_evicted_tag;

    // Shadow copy of the line state that the controller keeps.
    logic [TAG_OUT_W-1:0] shadow_tag [LINES];
    logic                 shadow_valid [LINES];
    logic                 shadow_dirty [LINES];

    t_cache_result pending_results[$];

    int  error_count = 0;
    int  sent_count = 0;
    int  hit_count = 0;
    int  miss_count = 0;
    int  evict_count = 0;
    int  writeback_count = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b1;

    logic [TAG_OUT_W-1:0] tag_pool [4];
    logic [INDEX_W-1:0]   index_pool [8];

    direct_mapped_writeback_cache_tags_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_address          (i_address),
        .i_action           (i_action),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_byte_offset      (o_byte_offset),
        .o_block_number     (o_block_number),
        .o_line_index       (o_line_index),
        .o_tag_value        (o_tag_value),
        .o_is_miss          (o_is_miss),
        .o_fetch_block      (o_fetch_block),
        .o_fetch_bytes      (o_fetch_bytes),
        .o_write_back       (o_write_back),
        .o_write_back_bytes (o_write_back_bytes),
        .o_replaced         (o_replaced),
        .o_evicted_tag      (o_evicted_tag)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_shadow();
        for (int i = 0; i < LINES; i++) begin
            shadow_tag[i] = '0;
            shadow_valid[i] = 1'b0;
            shadow_dirty[i] = 1'b0;
        end
    endfunction

    // Looks up one access in the shadow lines and applies the refill or dirty update.
    function automatic t_cache_result lookup_line(logic [ADDR_W-1:0] addr, logic wr);
        t_cache_result r;
        logic [BLOCK_W-1:0]   blk;
        logic [INDEX_W-1:0]   idx;
        logic [TAG_OUT_W-1:0] tg;
        blk = addr[ADDR_W-1:OFFSET_W];
        idx = blk[INDEX_W-1:0];
        tg  = blk[BLOCK_W-1:INDEX_W];
        r.byte_offset = addr[OFFSET_W-1:0];
        r.block_number = blk;
        r.line_index = idx;
        r.tag_value = tg;
        r.is_miss = 1'b0;
        r.fetch_block = 1'b0;
        r.fetch_bytes = '0;
        r.write_back = 1'b0;
        r.write_back_bytes = '0;
        r.replaced = 1'b0;
        r.evicted_tag = '0;
        if (shadow_valid[idx] && shadow_tag[idx] == tg) begin
            if (wr == ACT_WRITE) shadow_dirty[idx] = 1'b1;
        end else begin
            r.is_miss = 1'b1;
            r.fetch_block = 1'b1;
            r.fetch_bytes = BYTES_W'(BLOCK_SIZE);
            if (shadow_valid[idx]) begin
                r.replaced = 1'b1;
                r.evicted_tag = shadow_tag[idx];
                if (shadow_dirty[idx]) begin
                    r.write_back = 1'b1;
                    r.write_back_bytes = BYTES_W'(BLOCK_SIZE);
                end
            end
            shadow_tag[idx] = tg;
            shadow_valid[idx] = 1'b1;
            shadow_dirty[idx] = (wr == ACT_WRITE);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] make_address(logic [TAG_OUT_W-1:0] tg,
                                                       logic [INDEX_W-1:0] idx,
                                                       logic [OFFSET_W-1:0] off);
        return {tg, idx, off};
    endfunction

    // Mostly accesses from a few tags and lines so that hits and conflicts occur,
    // with some fully random addresses mixed in.
    function automatic logic [ADDR_W-1:0] pick_address();
        if ($urandom_range(0, 9) < 2) return $urandom;
        return make_address(tag_pool[$urandom_range(0, 3)], index_pool[$urandom_range(0, 7)],
                            OFFSET_W'($urandom_range(0, 31)));
    endfunction

    task automatic send_access(input logic [ADDR_W-1:0] addr, input logic wr);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_address <= addr;
        i_action <= wr;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pending_results.push_back(lookup_line(addr, wr));
        sent_count++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        send_access(make_address(20'h0, 7'd0, 5'd0), ACT_READ);       // miss on an invalid line
        send_access(make_address(20'h0, 7'd0, 5'd31), ACT_READ);      // read hit
        send_access(make_address(20'h0, 7'd0, 5'd16), ACT_WRITE);     // write hit marks dirty
        send_access(make_address(20'h1, 7'd0, 5'd0), ACT_READ);       // dirty eviction of tag 0
        send_access(make_address(20'h1, 7'd0, 5'd5), ACT_READ);
        send_access(make_address(20'h2, 7'd0, 5'd0), ACT_WRITE);      // clean eviction, write miss
        send_access(make_address(20'h2, 7'd0, 5'd1), ACT_READ);       // read hit keeps dirty
        send_access(make_address(20'h3, 7'd0, 5'd0), ACT_READ);
        send_access(32'hFFFF_FFFF, ACT_READ);
        send_access(32'hFFFF_FFFF, ACT_WRITE);
        send_access(make_address(20'h0, 7'd127, 5'd0), ACT_READ);
        send_access(make_address(20'hFFFFF, 7'd127, 5'd31), ACT_WRITE);
        send_access(make_address(20'hFFFFF, 7'd127, 5'd0), ACT_WRITE);
        send_access(make_address(20'h5A5A5, 7'h55, 5'h0A), ACT_WRITE);
        send_access(make_address(20'hA5A5A, 7'h55, 5'h15), ACT_WRITE);
        send_access(make_address(20'hA5A5A, 7'h2A, 5'h1F), ACT_READ);
        send_access(32'h8000_0000, ACT_READ);
        send_access(32'h7FFF_FFFF, ACT_READ);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++) send_access(pick_address(), logic'($urandom_range(0, 1)));
    endtask

    task automatic test_drain_pause();
        for (int n = 0; n < 4; n++) begin
            test_random_traffic(25);
            wait_drained();
        end
    endtask

    // Groups of accesses to one line, sent back to back, exercise the forwarding path.
    task automatic test_back_to_back_lines();
        logic [INDEX_W-1:0] idx;
        idle_on = 1'b0;
        for (int g = 0; g < 30; g++) begin
            idx = index_pool[$urandom_range(0, 7)];
            for (int k = 0; k < 6; k++)
                send_access(make_address(tag_pool[$urandom_range(0, 1)], idx,
                                         OFFSET_W'($urandom_range(0, 31))),
                            logic'($urandom_range(0, 1)));
        end
        wait_drained();
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_cache_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with no request outstanding, expected none actual %0h",
                         $time, o_block_number);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("byte_offset", want.byte_offset, o_byte_offset);
                compare_field("block_number", want.block_number, o_block_number);
                compare_field("line_index", want.line_index, o_line_index);
                compare_field("tag_value", want.tag_value, o_tag_value);
                compare_field("is_miss", want.is_miss, o_is_miss);
                compare_field("fetch_block", want.fetch_block, o_fetch_block);
                compare_field("fetch_bytes", want.fetch_bytes, o_fetch_bytes);
                compare_field("write_back", want.write_back, o_write_back);
                compare_field("write_back_bytes", want.write_back_bytes, o_write_back_bytes);
                compare_field("replaced", want.replaced, o_replaced);
                compare_field("evicted_tag", want.evicted_tag, o_evicted_tag);
                if (want.is_miss) miss_count++;
                else hit_count++;
                if (want.replaced) evict_count++;
                if (want.write_back) writeback_count++;
            end
        end
    end

    // The sweep after reset and the longest stalls stay far below the limit.
    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no request or result moved for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        clear_shadow();
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = TAG_OUT_W'($urandom);
        tag_pool[3] = TAG_OUT_W'($urandom);
        index_pool[0] = '0;
        index_pool[1] = '1;
        for (int i = 2; i < 8; i++) index_pool[i] = INDEX_W'($urandom);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(600);
        test_drain_pause();
        test_back_to_back_lines();

        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t ns: results missing, expected %0d more actual 0",
                     $time, pending_results.size());
            error_count++;
        end
        $display("Ran %0d accesses: %0d hits, %0d misses, %0d evictions, %0d write-backs.",
                 sent_count, hit_count, miss_count, evict_count, writeback_count);
        $display("Mismatches found: %0d", error_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
